// ===== hw/rtl/rpi_pkg.sv =====
// Shared widths, constants, types and codes of the ramped PI speed controller.
package rpi_pkg;

	// Field and state widths
	localparam int MEAS_W  = 16;
	localparam int SP_W    = 15;
	localparam int FREQ_W  = 13;
	localparam int ERR_W   = 18;
	localparam int DRIVE_W = 34;
	localparam int GN_W    = 24;
	localparam int GP_W    = 25;
	localparam int ACC_W   = 45;
	localparam int PROD_W  = 48;
	localparam int FRAC_W  = 28;
	localparam int SCALE_W = 14;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 25;

	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic        [PROD_W-1:0]  prod_t;
	typedef logic        [DRIVE_W-1:0] drive_t;

	// Upper limit of the PI output: 60 Hz with 28 fraction bits
	localparam drive_t U_MAX = drive_t'(60) << FRAC_W;

	// Centihertz scale: freq = floor(u * 13333 / (100 * 2^28))
	localparam logic [SCALE_W-1:0] FREQ_SCALE = 14'd13333;
	localparam prod_t DIV_TOP = prod_t'(100) << (FRAC_W + FREQ_W - 1);
	localparam logic [FREQ_W-1:0] FREQ_MAX = 13'd7999;

	// Register reset values
	localparam logic [SP_W-1:0]          RAMP_STEP_RST = 15'd960;
	localparam logic [GN_W-1:0]          GAIN_NOW_RST  = 24'd404980;
	localparam logic signed [GP_W-1:0]   GAIN_PREV_RST = -25'sd335544;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RUN_ENABLE   = 3'd0,
		CFG_CLOSED_LOOP  = 3'd1,
		CFG_TARGET_SPEED = 3'd2,
		CFG_TARGET_FREQ  = 3'd3,
		CFG_RAMP_STEP    = 3'd4,
		CFG_GAIN_NOW     = 3'd5,
		CFG_GAIN_PREV    = 3'd6
	} cfg_idx_t;

	// Tick sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAMP,
		ST_ERR,
		ST_MAC,
		ST_SUM,
		ST_SCALE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/ramped_pi_speed_controller_core.sv =====
// Top level of the ramped PI speed controller: registers, tick sequencer, output word.
//
// One input word on s_axis is one control tick and carries the measured speed
// (1/16 RPM). Each tick yields exactly one output word on m_axis with the drive
// frequency (centihertz), the ramped setpoint and the clamp flag.
// The cfg port writes one register per cycle while cfg_we is high; write it only
// while no tick is in flight.
// In stop or open-loop mode a tick goes from accept through the ramp state to the
// output register. In closed loop it also passes through the error, multiply, sum,
// scale and divide states, using the bit-serial error multiplier (one error bit
// per cycle, both terms in parallel lanes) and the restoring quotient unit that
// makes centihertz. A new word is accepted once the previous tick has reached the
// output register.
// If m_axis stalls, the finished word holds in the output register, the next
// tick may still be accepted and run, and it waits before its own output load.
// Reset (arst_n low) clears setpoint, PI history, the sequencer and the output
// valid, and loads the register defaults.
module ramped_pi_speed_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rpi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpi_pkg::CFG_DAT_W-1:0]     cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] measured_speed
	input  logic [15:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [12:0] drive_freq, [27:13] speed_setpoint, [28] output_clamped, [31:29] zero
	output logic [31:0]                       m_axis_tdata
);

	localparam int SP_PAD   = rpi_pkg::ERR_W - rpi_pkg::SP_W;
	localparam int MEAS_PAD = rpi_pkg::ERR_W - rpi_pkg::MEAS_W;
	localparam int DRV_PAD  = rpi_pkg::ACC_W - rpi_pkg::DRIVE_W;

	// Configuration registers
	logic                              run_enable_q;
	logic                              closed_loop_q;
	logic [rpi_pkg::SP_W-1:0]          target_speed_q;
	logic [rpi_pkg::FREQ_W-1:0]        target_freq_q;
	logic [rpi_pkg::SP_W-1:0]          ramp_step_q;
	logic [rpi_pkg::GN_W-1:0]          gain_now_q;
	logic signed [rpi_pkg::GP_W-1:0]   gain_prev_q;

	// Loop state
	logic [rpi_pkg::SP_W-1:0]          sp_q;
	logic signed [rpi_pkg::ERR_W-1:0]  prev_err_q;
	rpi_pkg::drive_t                   drive_q;

	// Tick work registers
	rpi_pkg::state_t                   state_q, state_d;
	logic [rpi_pkg::MEAS_W-1:0]        meas_q;
	logic [rpi_pkg::FREQ_W-1:0]        res_freq_q;
	logic                              res_clamp_q;
	logic                              out_valid_q;
	logic [31:0]                       out_data_q;

	// Sequencer outputs
	logic                              in_take;
	logic                              mac_start;
	logic                              div_start;
	logic                              out_load;

	// Datapath signals
	logic [rpi_pkg::SP_W-1:0]          sp_next;
	logic signed [rpi_pkg::ERR_W-1:0]  err;
	rpi_pkg::acc_t                     prod_now, prod_prev;
	rpi_pkg::acc_t                     u_sum;
	rpi_pkg::acc_t                     u_max_ext;
	rpi_pkg::drive_t                   u_clamped;
	logic                              u_hit;
	logic                              mac_done;
	logic                              div_done;
	logic [rpi_pkg::FREQ_W-1:0]        div_freq;
	logic                              in_fire;
	logic                              loop_on;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign loop_on = run_enable_q && closed_loop_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q   <= 1'b0;
			closed_loop_q  <= 1'b1;
			target_speed_q <= '0;
			target_freq_q  <= '0;
			ramp_step_q    <= rpi_pkg::RAMP_STEP_RST;
			gain_now_q     <= rpi_pkg::GAIN_NOW_RST;
			gain_prev_q    <= rpi_pkg::GAIN_PREV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rpi_pkg::CFG_RUN_ENABLE:   run_enable_q   <= cfg_wdata[0];
				rpi_pkg::CFG_CLOSED_LOOP:  closed_loop_q  <= cfg_wdata[0];
				rpi_pkg::CFG_TARGET_SPEED: target_speed_q <= cfg_wdata[rpi_pkg::SP_W-1:0];
				rpi_pkg::CFG_TARGET_FREQ:  target_freq_q  <= cfg_wdata[rpi_pkg::FREQ_W-1:0];
				rpi_pkg::CFG_RAMP_STEP:    ramp_step_q    <= cfg_wdata[rpi_pkg::SP_W-1:0];
				rpi_pkg::CFG_GAIN_NOW:     gain_now_q     <= cfg_wdata[rpi_pkg::GN_W-1:0];
				rpi_pkg::CFG_GAIN_PREV:    gain_prev_q    <= cfg_wdata[rpi_pkg::GP_W-1:0];
				default: ;
			endcase
		end
	end

	// Step the setpoint toward the target, stopping at the target
	always_comb begin
		sp_next = sp_q;
		if (sp_q < target_speed_q) begin
			if ((target_speed_q - sp_q) <= ramp_step_q) begin
				sp_next = target_speed_q;
			end else begin
				sp_next = sp_q + ramp_step_q;
			end
		end else if (sp_q > target_speed_q) begin
			if ((sp_q - target_speed_q) <= ramp_step_q) begin
				sp_next = target_speed_q;
			end else begin
				sp_next = sp_q - ramp_step_q;
			end
		end
	end

	// Speed error against the ramped setpoint
	assign err = $signed({{SP_PAD{1'b0}}, sp_q}) - $signed({{MEAS_PAD{1'b0}}, meas_q});

	// Sum the velocity-form terms and saturate to 0..60 Hz
	assign u_max_ext = rpi_pkg::acc_t'({{DRV_PAD{1'b0}}, rpi_pkg::U_MAX});
	assign u_sum = rpi_pkg::acc_t'({{DRV_PAD{1'b0}}, drive_q}) + prod_now + prod_prev;

	always_comb begin
		u_clamped = u_sum[rpi_pkg::DRIVE_W-1:0];
		u_hit     = 1'b0;
		if (u_sum > u_max_ext) begin
			u_clamped = rpi_pkg::U_MAX;
			u_hit     = 1'b1;
		end else if (u_sum < 0) begin
			u_clamped = '0;
			u_hit     = 1'b1;
		end
	end

	rpi_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mac_start),
		.err       (err),
		.prev_err  (prev_err_q),
		.gain_now  (gain_now_q),
		.gain_prev (gain_prev_q),
		.done      (mac_done),
		.prod_now  (prod_now),
		.prod_prev (prod_prev)
	);

	rpi_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.drive  (drive_q),
		.done   (div_done),
		.freq   (div_freq)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rpi_pkg::ST_IDLE:  if (in_fire) state_d = rpi_pkg::ST_RAMP;
			rpi_pkg::ST_RAMP:  state_d = loop_on ? rpi_pkg::ST_ERR : rpi_pkg::ST_DONE;
			rpi_pkg::ST_ERR:   state_d = rpi_pkg::ST_MAC;
			rpi_pkg::ST_MAC:   if (mac_done) state_d = rpi_pkg::ST_SUM;
			rpi_pkg::ST_SUM:   state_d = rpi_pkg::ST_SCALE;
			rpi_pkg::ST_SCALE: state_d = rpi_pkg::ST_DIV;
			rpi_pkg::ST_DIV:   if (div_done) state_d = rpi_pkg::ST_DONE;
			rpi_pkg::ST_DONE:  if (!out_valid_q || m_axis_tready) state_d = rpi_pkg::ST_IDLE;
			default:           state_d = rpi_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_take   = 1'b0;
		mac_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			rpi_pkg::ST_IDLE:  in_take   = 1'b1;
			rpi_pkg::ST_ERR:   mac_start = 1'b1;
			rpi_pkg::ST_SCALE: div_start = 1'b1;
			rpi_pkg::ST_DONE:  out_load  = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign s_axis_tready = in_take;

	// Advance the sequencer and the loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rpi_pkg::ST_IDLE;
			sp_q       <= '0;
			prev_err_q <= '0;
			drive_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rpi_pkg::ST_RAMP) begin
				if (loop_on) begin
					sp_q <= sp_next;
				end else begin
					sp_q       <= '0;
					prev_err_q <= '0;
					drive_q    <= '0;
				end
			end
			if (state_q == rpi_pkg::ST_SUM) begin
				drive_q    <= u_clamped;
				prev_err_q <= err;
			end
		end
	end

	// Capture the measurement and the tick result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meas_q <= s_axis_tdata[rpi_pkg::MEAS_W-1:0];
		end
		if (state_q == rpi_pkg::ST_RAMP && !loop_on) begin
			res_freq_q  <= run_enable_q ? target_freq_q : '0;
			res_clamp_q <= 1'b0;
		end
		if (state_q == rpi_pkg::ST_SUM) begin
			res_clamp_q <= u_hit;
		end
		if (state_q == rpi_pkg::ST_DIV && div_done) begin
			res_freq_q <= div_freq;
		end
		if (out_load) begin
			out_data_q <= {3'b000, res_clamp_q, sp_q, res_freq_q};
		end
	end

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Multiplier finishes only while the sequencer waits for it
	a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == rpi_pkg::ST_MAC)
		else $error("multiplier done outside its wait state");

	// Sum stage is entered only right after the multiplier finished
	a_sum_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rpi_pkg::ST_SUM |-> $past(mac_done))
		else $error("sum stage entered without multiplier result");

	// Kept PI output stays within the saturation range
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q <= rpi_pkg::U_MAX)
		else $error("stored PI output above limit");

	// Converted frequency never exceeds the 60 Hz equivalent
	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_freq <= rpi_pkg::FREQ_MAX)
		else $error("converted frequency out of range");

endmodule

// ===== hw/rtl/rpi_mac.sv =====
// Bit-serial two-lane shift-add multiplier for the PI error terms.
module rpi_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [rpi_pkg::ERR_W-1:0]  err,
	input  logic signed [rpi_pkg::ERR_W-1:0]  prev_err,
	input  logic        [rpi_pkg::GN_W-1:0]   gain_now,
	input  logic signed [rpi_pkg::GP_W-1:0]   gain_prev,
	output logic                              done,
	output rpi_pkg::acc_t                     prod_now,
	output rpi_pkg::acc_t                     prod_prev
);

	localparam int CNT_W = $clog2(rpi_pkg::ERR_W);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(rpi_pkg::ERR_W - 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	rpi_pkg::acc_t                mc_a_q, mc_b_q;
	logic [rpi_pkg::ERR_W-1:0]    ml_a_q, ml_b_q;
	rpi_pkg::acc_t                acc_a_q, acc_b_q;
	rpi_pkg::acc_t                term_a, term_b;

	// Select this bit's partial products; the sign bit carries negative weight
	always_comb begin
		term_a = ml_a_q[0] ? mc_a_q : '0;
		term_b = ml_b_q[0] ? mc_b_q : '0;
	end

	// Control: count one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift multiplicands left, multipliers right, accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			mc_a_q  <= rpi_pkg::acc_t'({{(rpi_pkg::ACC_W-rpi_pkg::GN_W){1'b0}}, gain_now});
			mc_b_q  <= rpi_pkg::acc_t'({{(rpi_pkg::ACC_W-rpi_pkg::GP_W){gain_prev[rpi_pkg::GP_W-1]}},
				gain_prev});
			ml_a_q  <= err;
			ml_b_q  <= prev_err;
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (busy_q) begin
			mc_a_q <= mc_a_q <<< 1;
			mc_b_q <= mc_b_q <<< 1;
			ml_a_q <= ml_a_q >> 1;
			ml_b_q <= ml_b_q >> 1;
			if (cnt_q == LAST_BIT) begin
				acc_a_q <= acc_a_q - term_a;
				acc_b_q <= acc_b_q - term_b;
			end else begin
				acc_a_q <= acc_a_q + term_a;
				acc_b_q <= acc_b_q + term_b;
			end
		end
	end

	assign done      = done_q;
	assign prod_now  = acc_a_q;
	assign prod_prev = acc_b_q;

endmodule

// ===== hw/rtl/rpi_fdiv.sv =====
// Centihertz conversion: constant scale, then one quotient bit per cycle.
module rpi_fdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rpi_pkg::drive_t             drive,
	output logic                        done,
	output logic [rpi_pkg::FREQ_W-1:0]  freq
);

	localparam int CNT_W = $clog2(rpi_pkg::FREQ_W);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(rpi_pkg::FREQ_W - 1);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	rpi_pkg::prod_t              rem_q;
	rpi_pkg::prod_t              dv_q;
	logic [rpi_pkg::FREQ_W-1:0]  quo_q;
	logic                        fits;

	assign fits = (rem_q >= dv_q);

	// Control: one restoring step per cycle, most significant bit first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: scale on start, then compare and subtract the shifted divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rpi_pkg::prod_t'(drive) * rpi_pkg::prod_t'(rpi_pkg::FREQ_SCALE);
			dv_q  <= rpi_pkg::DIV_TOP;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dv_q;
			end
			dv_q  <= dv_q >> 1;
			quo_q <= {quo_q[rpi_pkg::FREQ_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign freq = quo_q;

endmodule

// ===== test/testbench.sv =====
// Testbench of the ramped PI speed controller: directed and random ticks against a bit-exact predictor.
module testbench;

	localparam int     FRAC_W         = rpi_pkg::FRAC_W;
	localparam int     FREQ_W         = rpi_pkg::FREQ_W;
	localparam int     SP_W           = rpi_pkg::SP_W;
	localparam int     GN_W           = rpi_pkg::GN_W;
	localparam int     GP_W           = rpi_pkg::GP_W;
	localparam int     MEAS_W         = rpi_pkg::MEAS_W;
	localparam int     CFG_IDX_W      = rpi_pkg::CFG_IDX_W;
	localparam int     CFG_DAT_W      = rpi_pkg::CFG_DAT_W;
	localparam int     LONG_HOLD      = 400;
	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     RANDOM_ITEMS   = 590;
	localparam int     TAIL_CYCLES    = 60;
	localparam longint CENTI_DIVISOR  = longint'(100) << FRAC_W;
	localparam longint DRIVE_LIMIT    = longint'(rpi_pkg::U_MAX);

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [SP_W-1:0]   setpoint;
		logic              clamped;
	} ctl_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;

	// Register copies and loop state of the predictor
	logic                   run_en;
	logic                   loop_closed;
	logic [SP_W-1:0]        tgt_speed;
	logic [FREQ_W-1:0]      tgt_freq;
	logic [SP_W-1:0]        ramp_step;
	logic [GN_W-1:0]        kp_now;
	logic signed [GP_W-1:0] kp_prev;
	logic [SP_W-1:0]        sp_q;
	longint                 err_q;
	longint                 drive_q;

	ctl_word_t due_words[$];
	ctl_word_t want;
	int        error_count = 0;
	int        idle_cycles = 0;
	logic      long_hold_req = 1'b0;
	logic      steady_flow = 1'b0;

	always #6 clk = ~clk;

	ramped_pi_speed_controller_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Work out the output word of one control tick and advance the loop state
	function automatic ctl_word_t tick_controller(logic [MEAS_W-1:0] meas);
		ctl_word_t w;
		longint    err;
		longint    drive;
		w = '0;
		if (run_en && loop_closed) begin
			// move the setpoint toward the target, stop on it
			if (sp_q < tgt_speed)
				sp_q = (tgt_speed - sp_q <= ramp_step) ? tgt_speed : sp_q + ramp_step;
			else if (sp_q > tgt_speed)
				sp_q = (sp_q - tgt_speed <= ramp_step) ? tgt_speed : sp_q - ramp_step;
			err   = longint'(sp_q) - longint'(meas);
			drive = drive_q + longint'(kp_now) * err + longint'(kp_prev) * err_q;
			// saturate to 0..60 Hz and keep the saturated value
			if (drive > DRIVE_LIMIT) begin
				drive     = DRIVE_LIMIT;
				w.clamped = 1'b1;
			end else if (drive < 0) begin
				drive     = 0;
				w.clamped = 1'b1;
			end
			drive_q = drive;
			err_q   = err;
			w.freq  = FREQ_W'(drive * longint'(rpi_pkg::FREQ_SCALE) / CENTI_DIVISOR);
		end else begin
			// stop and open loop both drop the PI history
			sp_q    = '0;
			err_q   = 0;
			drive_q = 0;
			w.freq  = run_en ? tgt_freq : '0;
		end
		w.setpoint = sp_q;
		return w;
	endfunction

	// Random register value, zero or all ones now and then
	function automatic logic [CFG_DAT_W-1:0] pick_extreme(int w);
		logic [CFG_DAT_W-1:0] mask;
		mask = (CFG_DAT_W'(1) << w) - 1'b1;
		case ($urandom_range(0, 7))
			0: return '0;
			1: return mask;
			default: return CFG_DAT_W'($urandom) & mask;
		endcase
	endfunction

	// Write one register and mirror it in the predictor
	task automatic write_reg(rpi_pkg::cfg_idx_t idx, logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			rpi_pkg::CFG_RUN_ENABLE:   run_en = val[0];
			rpi_pkg::CFG_CLOSED_LOOP:  loop_closed = val[0];
			rpi_pkg::CFG_TARGET_SPEED: tgt_speed = val[SP_W-1:0];
			rpi_pkg::CFG_TARGET_FREQ:  tgt_freq = val[FREQ_W-1:0];
			rpi_pkg::CFG_RAMP_STEP:    ramp_step = val[SP_W-1:0];
			rpi_pkg::CFG_GAIN_NOW:     kp_now = val[GN_W-1:0];
			rpi_pkg::CFG_GAIN_PREV:    kp_prev = val[GP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one speed word after a gap, predict its result once accepted
	task automatic send_speed(logic [MEAS_W-1:0] meas, int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= meas;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		due_words.push_back(tick_controller(meas));
	endtask

	// Stop offering and wait for every due word
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_stop_mode();
		// stopped after reset: zero out whatever the speed
		send_speed(16'd0, 0);
		send_speed(16'hFFFF, 1);
		send_speed(16'd12345, 0);
		drain();
		// run with register defaults
		write_reg(rpi_pkg::CFG_RUN_ENABLE, CFG_DAT_W'(1));
		send_speed(16'hFFFF, 0);
		send_speed(16'd0, 2);
		send_speed(16'd0, 0);
	endtask

	task automatic test_exact_limits();
		drain();
		write_reg(rpi_pkg::CFG_RUN_ENABLE, CFG_DAT_W'(0));
		send_speed(16'd0, 0);
		drain();
		write_reg(rpi_pkg::CFG_GAIN_PREV, '0);
		write_reg(rpi_pkg::CFG_GAIN_NOW, CFG_DAT_W'(15) << 20);
		write_reg(rpi_pkg::CFG_RAMP_STEP, CFG_DAT_W'(15'h7FFF));
		write_reg(rpi_pkg::CFG_TARGET_SPEED, CFG_DAT_W'(1024));
		write_reg(rpi_pkg::CFG_RUN_ENABLE, CFG_DAT_W'(1));
		// sum lands exactly on 60 Hz, then zero error holds it there
		send_speed(16'd0, 0);
		send_speed(16'd1024, 0);
		// one count over the top, then far over speed to the bottom
		send_speed(16'd1023, 0);
		send_speed(16'hFFFF, 0);
		// zero error from zero: exactly 0 Hz, not saturated
		send_speed(16'd1024, 0);
	endtask

	task automatic test_open_loop();
		drain();
		write_reg(rpi_pkg::CFG_CLOSED_LOOP, CFG_DAT_W'(0));
		write_reg(rpi_pkg::CFG_TARGET_FREQ, CFG_DAT_W'(13'h1FFF));
		send_speed(16'd500, 0);
		drain();
		write_reg(rpi_pkg::CFG_TARGET_FREQ, CFG_DAT_W'(0));
		send_speed(16'hFFFF, 1);
		drain();
		write_reg(rpi_pkg::CFG_TARGET_FREQ, CFG_DAT_W'(6000));
		send_speed(16'd1, 0);
	endtask

	task automatic test_ramp_cases();
		drain();
		write_reg(rpi_pkg::CFG_CLOSED_LOOP, CFG_DAT_W'(1));
		write_reg(rpi_pkg::CFG_GAIN_NOW, CFG_DAT_W'(rpi_pkg::GAIN_NOW_RST));
		write_reg(rpi_pkg::CFG_GAIN_PREV, rpi_pkg::GAIN_PREV_RST);
		// zero step: setpoint holds below the target
		write_reg(rpi_pkg::CFG_RAMP_STEP, CFG_DAT_W'(0));
		write_reg(rpi_pkg::CFG_TARGET_SPEED, CFG_DAT_W'(500));
		send_speed(16'd0, 0);
		send_speed(16'd0, 0);
		drain();
		// ramp up toward the top target
		write_reg(rpi_pkg::CFG_RAMP_STEP, CFG_DAT_W'(300));
		write_reg(rpi_pkg::CFG_TARGET_SPEED, CFG_DAT_W'(15'h7FFF));
		send_speed(16'd300, 0);
		send_speed(16'd600, 1);
		drain();
		// full step: jump straight down to zero
		write_reg(rpi_pkg::CFG_TARGET_SPEED, CFG_DAT_W'(0));
		write_reg(rpi_pkg::CFG_RAMP_STEP, CFG_DAT_W'(15'h7FFF));
		send_speed(16'd0, 0);
		drain();
		// largest gains, previous-error gain with a positive pattern
		write_reg(rpi_pkg::CFG_GAIN_NOW, CFG_DAT_W'(24'hFFFFFF));
		write_reg(rpi_pkg::CFG_GAIN_PREV, 25'h0FFFFFF);
		send_speed(16'h5555, 0);
		drain();
		write_reg(rpi_pkg::CFG_GAIN_PREV, 25'h1000000);
		send_speed(16'hAAAA, 0);
	endtask

	task automatic test_backpressure();
		drain();
		write_reg(rpi_pkg::CFG_RUN_ENABLE, CFG_DAT_W'(1));
		write_reg(rpi_pkg::CFG_CLOSED_LOOP, CFG_DAT_W'(1));
		write_reg(rpi_pkg::CFG_TARGET_SPEED, CFG_DAT_W'(8000));
		write_reg(rpi_pkg::CFG_RAMP_STEP, CFG_DAT_W'(960));
		write_reg(rpi_pkg::CFG_GAIN_NOW, CFG_DAT_W'(rpi_pkg::GAIN_NOW_RST));
		write_reg(rpi_pkg::CFG_GAIN_PREV, rpi_pkg::GAIN_PREV_RST);
		// receiver holds off while words keep coming
		long_hold_req = 1'b1;
		repeat (24) send_speed(MEAS_W'(sp_q + $urandom_range(0, 64)), 0);
		drain();
	endtask

	task automatic test_random_phases();
		int               done;
		int               pick;
		int               gap;
		int               span;
		int               near;
		logic [GN_W-1:0]  gn;
		logic [MEAS_W-1:0] meas;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			drain();
			steady_flow = ($urandom_range(0, 4) == 0);
			// mostly closed loop, some open loop and stop
			pick = $urandom_range(0, 19);
			write_reg(rpi_pkg::CFG_RUN_ENABLE, CFG_DAT_W'(pick >= 2));
			write_reg(rpi_pkg::CFG_CLOSED_LOOP, CFG_DAT_W'(pick >= 4));
			if ($urandom_range(0, 2) == 0)
				write_reg(rpi_pkg::CFG_TARGET_SPEED, pick_extreme(SP_W));
			if (pick < 4 || $urandom_range(0, 2) == 0)
				write_reg(rpi_pkg::CFG_TARGET_FREQ, pick_extreme(FREQ_W));
			if ($urandom_range(0, 2) == 0)
				write_reg(rpi_pkg::CFG_RAMP_STEP, ($urandom_range(0, 3) == 0) ?
					pick_extreme(SP_W) : CFG_DAT_W'($urandom_range(1, 2000)));
			// gains: sometimes a sane pair, now and then any pattern, else unchanged
			pick = $urandom_range(0, 7);
			if (pick == 0) begin
				write_reg(rpi_pkg::CFG_GAIN_NOW, pick_extreme(GN_W));
				write_reg(rpi_pkg::CFG_GAIN_PREV, pick_extreme(GP_W));
			end else if (pick < 4) begin
				gn = GN_W'($urandom_range(0, 1 << 21));
				write_reg(rpi_pkg::CFG_GAIN_NOW, CFG_DAT_W'(gn));
				write_reg(rpi_pkg::CFG_GAIN_PREV, CFG_DAT_W'(-int'($urandom_range(0, gn))));
			end
			repeat ($urandom_range(8, 40)) begin
				// speed near the setpoint, or anything at all
				if ($urandom_range(0, 3) == 0) begin
					meas = MEAS_W'($urandom);
				end else begin
					span = $urandom_range(0, 1) ? 256 : 8;
					near = int'(sp_q) + int'($urandom_range(0, 2 * span)) - span;
					if (near < 0)
						near = 0;
					meas = MEAS_W'(near);
				end
				pick = $urandom_range(0, 99);
				if (steady_flow || pick < 70)
					gap = 0;
				else if (pick < 95)
					gap = $urandom_range(1, 3);
				else
					gap = $urandom_range(10, 60);
				send_speed(meas, gap);
				done++;
			end
		end
	endtask

	// Receiver: random stalls, long hold-off on request
	initial begin
		int hold;
		m_axis_tready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else if (steady_flow || $urandom_range(0, 99) < 70) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
			end
		end
	end

	// Compare each output word with the oldest due word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_words.size() == 0) begin
				$error("output word with nothing due: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = due_words.pop_front();
				if (m_axis_tdata[FREQ_W-1:0] !== want.freq) begin
					$error("drive_freq: expected %0d, got %0d", want.freq,
						m_axis_tdata[FREQ_W-1:0]);
					error_count++;
				end
				if (m_axis_tdata[FREQ_W +: SP_W] !== want.setpoint) begin
					$error("speed_setpoint: expected %0d, got %0d", want.setpoint,
						m_axis_tdata[FREQ_W +: SP_W]);
					error_count++;
				end
				if (m_axis_tdata[FREQ_W+SP_W] !== want.clamped) begin
					$error("output_clamped: expected %0d, got %0d", want.clamped,
						m_axis_tdata[FREQ_W+SP_W]);
					error_count++;
				end
				if (m_axis_tdata[31:FREQ_W+SP_W+1] !== '0) begin
					$error("pad bits: expected 0, got %b", m_axis_tdata[31:FREQ_W+SP_W+1]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = rpi_pkg::CFG_RUN_ENABLE;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		run_en        = 1'b0;
		loop_closed   = 1'b1;
		tgt_speed     = '0;
		tgt_freq      = '0;
		ramp_step     = rpi_pkg::RAMP_STEP_RST;
		kp_now        = rpi_pkg::GAIN_NOW_RST;
		kp_prev       = rpi_pkg::GAIN_PREV_RST;
		sp_q          = '0;
		err_q         = 0;
		drive_q       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_stop_mode();
		test_exact_limits();
		test_open_loop();
		test_ramp_cases();
		test_backpressure();
		test_random_phases();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== ramped_pi_speed_controller_core.f =====
hw/rtl/rpi_pkg.sv
hw/rtl/rpi_mac.sv
hw/rtl/rpi_fdiv.sv
hw/rtl/ramped_pi_speed_controller_core.sv
test/testbench.sv
